>>> hdl/ttvfp_pkg.sv
// ----------------------------------------------------------------------------
// ttvfp_pkg
// shared types, constants and tag tables for the text tag/value frame parser
// ----------------------------------------------------------------------------
package ttvfp_pkg;

   localparam int DEF_MAX_FIELDS  = 32;
   localparam int DEF_TAG_CHARS   = 8;
   localparam int DEF_VALUE_CHARS = 16;
   localparam int NUM_TAGS        = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [35:0] SAT_MAG = 36'h0_8000_0000;

   localparam logic [1:0] TAG_PPV = 2'd0;
   localparam logic [1:0] TAG_V   = 2'd1;
   localparam logic [1:0] TAG_ERR = 2'd2;
   localparam logic [1:0] TAG_CS  = 2'd3;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_CR,
      KIND_LF,
      KIND_TAB
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_TAG,
      PHASE_VALUE
   } phase_type;

   typedef enum logic [1:0] {
      STAGE_LEAD,
      STAGE_DIGITS,
      STAGE_DONE
   } stage_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } item_type;

   function automatic logic [1:0] cand_len(input logic [1:0] k);
      logic [1:0] len;
      unique case (k)
         TAG_PPV: len = 2'd3;
         TAG_V:   len = 2'd1;
         TAG_ERR: len = 2'd3;
         TAG_CS:  len = 2'd2;
         default: len = 2'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [1:0] pos);
      logic [7:0] c;
      unique case ({k, pos})
         {TAG_PPV, 2'd0}: c = "P";
         {TAG_PPV, 2'd1}: c = "P";
         {TAG_PPV, 2'd2}: c = "V";
         {TAG_V,   2'd0}: c = "V";
         {TAG_ERR, 2'd0}: c = "E";
         {TAG_ERR, 2'd1}: c = "R";
         {TAG_ERR, 2'd2}: c = "R";
         {TAG_CS,  2'd0}: c = "C";
         {TAG_CS,  2'd1}: c = "S";
         default:         c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/ttvfp_front.sv
// ----------------------------------------------------------------------------
// ttvfp_front
// accepts request bytes, classifies control characters and queues them
// ----------------------------------------------------------------------------
module ttvfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                item_valid,
   input  logic                item_ready,
   output ttvfp_pkg::item_type item
);
   import ttvfp_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   item_type        entry;
   logic            push;
   logic            pop;

   always_comb begin
      entry.data = req_tdata;
      entry.last = req_tlast;
      unique case (req_tdata)
         CHAR_CR:  entry.kind = KIND_CR;
         CHAR_LF:  entry.kind = KIND_LF;
         CHAR_TAB: entry.kind = KIND_TAB;
         default:  entry.kind = KIND_CHAR;
      endcase
   end

   assign req_tready = (count_ff != CW'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
`endif

endmodule

>>> hdl/ttvfp_back.sv
// ----------------------------------------------------------------------------
// ttvfp_back
// tag matching, value parsing, checksum and commit of held values
// ----------------------------------------------------------------------------
module ttvfp_back #(
   parameter int MAX_FIELDS  = ttvfp_pkg::DEF_MAX_FIELDS,
   parameter int TAG_CHARS   = ttvfp_pkg::DEF_TAG_CHARS,
   parameter int VALUE_CHARS = ttvfp_pkg::DEF_VALUE_CHARS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  ttvfp_pkg::item_type item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                checksum_ok,
   output logic [31:0]         power_watts,
   output logic [31:0]         voltage_millivolts,
   output logic [31:0]         error_code,
   output logic [31:0]         charge_state,
   output logic                fields_dropped
);
   import ttvfp_pkg::*;

   localparam int TCW = $clog2(TAG_CHARS + 1);
   localparam int VCW = $clog2(VALUE_CHARS + 1);
   localparam int FCW = $clog2(MAX_FIELDS + 1);

   phase_type              phase_ff, phase_in, phase_post;
   logic [TCW-1:0]         tag_count_ff, tag_count_in, tag_count_post;
   logic [NUM_TAGS-1:0]    tag_match_ff, tag_match_in, tag_match_post;
   logic                   tag_overlong_ff, tag_overlong_in, tag_overlong_post;
   logic [VCW-1:0]         value_chars_ff, value_chars_in, value_chars_post;
   logic [31:0]            value_accum_ff, value_accum_in, value_accum_post;
   stage_type              stage_ff, stage_in, stage_post;
   logic                   neg_ff, neg_in, neg_post;
   logic [FCW-1:0]         field_count_ff, field_count_in;
   logic [7:0]             byte_sum_ff, byte_sum_in, byte_sum_post;
   logic                   dropped_ff, dropped_in, dropped_post;
   logic [31:0]            pending_ff [NUM_TAGS];
   logic [31:0]            pending_in [NUM_TAGS];
   logic [NUM_TAGS-1:0]    pending_valid_ff, pending_valid_in, pending_valid_new;
   logic [31:0]            held_ff [NUM_TAGS];
   logic [31:0]            held_in [NUM_TAGS];
   logic                   ok_ff, ok_in;
   logic                   drop_out_ff, drop_out_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   pop;
   logic                   finish;
   logic                   is_digit;
   logic [35:0]            product;
   logic [31:0]            digit_accum;
   logic [31:0]            field_value;
   logic                   sum_ok;

   assign item_ready = !item.last || !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   assign is_digit = (item.data >= CHAR_ZERO) && (item.data <= CHAR_NINE);
   assign product  = ({4'b0, value_accum_ff} << 3) + ({4'b0, value_accum_ff} << 1)
                   + {32'b0, item.data[3:0]};
   assign digit_accum = (product > SAT_MAG) ? SAT_MAG[31:0] : product[31:0];

   always_comb begin
      phase_post        = phase_ff;
      tag_count_post    = tag_count_ff;
      tag_match_post    = tag_match_ff;
      tag_overlong_post = tag_overlong_ff;
      value_chars_post  = value_chars_ff;
      value_accum_post  = value_accum_ff;
      stage_post        = stage_ff;
      neg_post          = neg_ff;
      dropped_post      = dropped_ff;
      byte_sum_post     = byte_sum_ff + item.data;

      unique case (item.kind)
         KIND_CR: begin
         end
         KIND_LF, KIND_TAB: begin
            if (field_count_ff >= FCW'(MAX_FIELDS)) begin
               dropped_post = 1'b1;
            end
            phase_post = (item.kind == KIND_LF) ? PHASE_TAG : PHASE_VALUE;
         end
         default: begin
            if (phase_ff == PHASE_TAG) begin
               if (tag_count_ff >= TCW'(TAG_CHARS)) begin
                  tag_overlong_post = 1'b1;
                  tag_match_post    = '0;
               end else begin
                  for (int k = 0; k < NUM_TAGS; k++) begin
                     if ((tag_count_ff >= TCW'(cand_len(2'(k))))
                         || (item.data != cand_char(2'(k), tag_count_ff[1:0]))) begin
                        tag_match_post[k] = 1'b0;
                     end
                  end
                  tag_count_post = tag_count_ff + 1'b1;
               end
            end else if (phase_ff == PHASE_VALUE) begin
               if (value_chars_ff < VCW'(VALUE_CHARS)) begin
                  value_chars_post = value_chars_ff + 1'b1;
                  unique case (stage_ff)
                     STAGE_LEAD: begin
                        priority if (item.data == CHAR_SPACE || item.data == CHAR_VT
                                     || item.data == CHAR_FF) begin
                           stage_post = STAGE_LEAD;
                        end else if (item.data == CHAR_PLUS) begin
                           stage_post = STAGE_DIGITS;
                        end else if (item.data == CHAR_MINUS) begin
                           stage_post = STAGE_DIGITS;
                           neg_post   = 1'b1;
                        end else if (is_digit) begin
                           stage_post       = STAGE_DIGITS;
                           value_accum_post = digit_accum;
                        end else begin
                           stage_post = STAGE_DONE;
                        end
                     end
                     STAGE_DIGITS: begin
                        if (is_digit) begin
                           value_accum_post = digit_accum;
                        end else begin
                           stage_post = STAGE_DONE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      endcase
   end

   assign finish = (phase_post != PHASE_IDLE) && ((item.kind == KIND_CR) || item.last);
   assign field_value = neg_post ? (32'd0 - value_accum_post)
                      : ((value_accum_post > SAT_POS) ? SAT_POS : value_accum_post);
   assign sum_ok = (byte_sum_post == 8'd0);

   always_comb begin
      pending_in        = pending_ff;
      pending_valid_new = pending_valid_ff;
      if (finish && (field_count_ff < FCW'(MAX_FIELDS)) && !tag_overlong_post) begin
         for (int k = 0; k < NUM_TAGS; k++) begin
            if (tag_match_post[k] && (tag_count_post == TCW'(cand_len(2'(k))))) begin
               pending_in[k]        = field_value;
               pending_valid_new[k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      tag_count_in     = tag_count_ff;
      tag_match_in     = tag_match_ff;
      tag_overlong_in  = tag_overlong_ff;
      value_chars_in   = value_chars_ff;
      value_accum_in   = value_accum_ff;
      stage_in         = stage_ff;
      neg_in           = neg_ff;
      field_count_in   = field_count_ff;
      byte_sum_in      = byte_sum_ff;
      dropped_in       = dropped_ff;
      pending_valid_in = pending_valid_ff;
      held_in          = held_ff;
      ok_in            = ok_ff;
      drop_out_in      = drop_out_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;

      if (pop) begin
         if (item.last) begin
            for (int k = 0; k < NUM_TAGS; k++) begin
               if (sum_ok && pending_valid_new[k]) begin
                  held_in[k] = pending_in[k];
               end
            end
            ok_in            = sum_ok;
            drop_out_in      = dropped_post;
            rsp_valid_in     = 1'b1;
            phase_in         = PHASE_IDLE;
            tag_count_in     = '0;
            tag_match_in     = '1;
            tag_overlong_in  = 1'b0;
            value_chars_in   = '0;
            value_accum_in   = '0;
            stage_in         = STAGE_LEAD;
            neg_in           = 1'b0;
            field_count_in   = '0;
            byte_sum_in      = '0;
            dropped_in       = 1'b0;
            pending_valid_in = '0;
         end else begin
            byte_sum_in      = byte_sum_post;
            dropped_in       = dropped_post;
            pending_valid_in = pending_valid_new;
            if (finish) begin
               phase_in        = PHASE_IDLE;
               tag_count_in    = '0;
               tag_match_in    = '1;
               tag_overlong_in = 1'b0;
               value_chars_in  = '0;
               value_accum_in  = '0;
               stage_in        = STAGE_LEAD;
               neg_in          = 1'b0;
               if (field_count_ff < FCW'(MAX_FIELDS)) begin
                  field_count_in = field_count_ff + 1'b1;
               end
            end else begin
               phase_in        = phase_post;
               tag_count_in    = tag_count_post;
               tag_match_in    = tag_match_post;
               tag_overlong_in = tag_overlong_post;
               value_chars_in  = value_chars_post;
               value_accum_in  = value_accum_post;
               stage_in        = stage_post;
               neg_in          = neg_post;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_IDLE;
         tag_count_ff     <= '0;
         tag_match_ff     <= '1;
         tag_overlong_ff  <= 1'b0;
         value_chars_ff   <= '0;
         value_accum_ff   <= '0;
         stage_ff         <= STAGE_LEAD;
         neg_ff           <= 1'b0;
         field_count_ff   <= '0;
         byte_sum_ff      <= '0;
         dropped_ff       <= 1'b0;
         pending_valid_ff <= '0;
         ok_ff            <= 1'b0;
         drop_out_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < NUM_TAGS; k++) begin
            held_ff[k] <= '0;
         end
      end else begin
         phase_ff         <= phase_in;
         tag_count_ff     <= tag_count_in;
         tag_match_ff     <= tag_match_in;
         tag_overlong_ff  <= tag_overlong_in;
         value_chars_ff   <= value_chars_in;
         value_accum_ff   <= value_accum_in;
         stage_ff         <= stage_in;
         neg_ff           <= neg_in;
         field_count_ff   <= field_count_in;
         byte_sum_ff      <= byte_sum_in;
         dropped_ff       <= dropped_in;
         pending_valid_ff <= pending_valid_in;
         ok_ff            <= ok_in;
         drop_out_ff      <= drop_out_in;
         rsp_valid_ff     <= rsp_valid_in;
         held_ff          <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pending_ff <= pending_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign checksum_ok        = ok_ff;
   assign power_watts        = held_ff[TAG_PPV];
   assign voltage_millivolts = held_ff[TAG_V];
   assign error_code         = held_ff[TAG_ERR];
   assign charge_state       = held_ff[TAG_CS];
   assign fields_dropped     = drop_out_ff;

`ifndef SYNTH
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (pop && item.last) |=> rsp_valid_ff)
      else $error("frame end did not raise a response");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(held_ff[TAG_PPV]) && $stable(held_ff[TAG_CS]))
      else $error("held values changed under a stalled response");
`endif

endmodule

>>> hdl/text_tag_value_frame_parser.sv
// path: a byte is registered in the front queue before it reaches the parser; the
// response is registered in the back once the frame's last byte is accepted there
// throughput: one byte per cycle, with the combinational multiply-by-ten step
// of the value accumulator and a two-entry queue between front and back;
// a frame's last byte waits while the previous response is not yet taken
// reset: synchronous; clears the parser, the queue and the held values to zero
// ----------------------------------------------------------------------------
// text_tag_value_frame_parser
// byte-stream parser for tag/value text frames with checksum-gated commit
// ----------------------------------------------------------------------------
module text_tag_value_frame_parser #(
   parameter int MAX_FIELDS  = ttvfp_pkg::DEF_MAX_FIELDS,
   parameter int TAG_CHARS   = ttvfp_pkg::DEF_TAG_CHARS,
   parameter int VALUE_CHARS = ttvfp_pkg::DEF_VALUE_CHARS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   input  logic         req_tlast,   // frame_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata    // checksum_ok, power_watts, voltage_millivolts,
                                     // error_code, charge_state, fields_dropped, pad
);
   import ttvfp_pkg::*;

   item_type    item;
   logic        item_valid;
   logic        item_ready;
   logic        checksum_ok;
   logic [31:0] power_watts;
   logic [31:0] voltage_millivolts;
   logic [31:0] error_code;
   logic [31:0] charge_state;
   logic        fields_dropped;

   ttvfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   ttvfp_back #(
      .MAX_FIELDS  (MAX_FIELDS),
      .TAG_CHARS   (TAG_CHARS),
      .VALUE_CHARS (VALUE_CHARS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item_ready         (item_ready),
      .item               (item),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .checksum_ok        (checksum_ok),
      .power_watts        (power_watts),
      .voltage_millivolts (voltage_millivolts),
      .error_code         (error_code),
      .charge_state       (charge_state),
      .fields_dropped     (fields_dropped)
   );

   assign rsp_tdata = {6'b0, fields_dropped, charge_state, error_code,
                       voltage_millivolts, power_watts, checksum_ok};

endmodule
